// ===== src/pali_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pali_pkg
// Shared types and constants of the polyline arc-length interpolator.
// ----------------------------------------------------------------------------
package pali_pkg;

    localparam int POINTS = 256;
    localparam int IDX_W  = $clog2(POINTS);
    localparam int CNT_W  = $clog2(POINTS + 1);
    localparam int NUM_W  = 58;

    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_REVERSE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic CFG_LANE_LENGTH = 1'b0;
    localparam logic CFG_END_TOL     = 1'b1;

    localparam logic [15:0] HALF_TURN = 16'h8000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic [15:0]        heading;
        logic [23:0]        s_pos;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [15:0]        out_heading;
        logic [23:0]        out_s;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        heading;
        logic [23:0]        s;
    } t_point;

endpackage

// ===== src/pali_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pali_div
// Bit-serial signed by unsigned divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module pali_div
    import pali_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [23:0]             i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(NUM_W + 1);

    logic                r_busy;
    logic                r_done;
    logic                r_neg;
    logic [CNT_BITS-1:0] r_cnt;
    logic [NUM_W-1:0]    r_mag;
    logic [NUM_W-1:0]    r_quo;
    logic [23:0]         r_rem;
    logic [23:0]         r_den;
    logic [24:0]         w_trial;
    logic                w_fit;

    assign w_trial = {r_rem, r_mag[NUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_W);
                r_neg  <= i_num[NUM_W-1];
                r_mag  <= i_num[NUM_W-1] ? NUM_W'(-i_num) : i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_mag <= {r_mag[NUM_W-2:0], 1'b0};
                r_quo <= {r_quo[NUM_W-2:0], w_fit};
                r_rem <= w_fit ? 24'(w_trial - {1'b0, r_den}) : w_trial[23:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? NUM_W'(-$signed(r_quo)) : $signed(r_quo);

endmodule

// ===== src/polyline_arc_length_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_arc_length_interpolator
// Double-ended store of lane reference points with arc-length queries.
// ----------------------------------------------------------------------------
// Appends, reversed inserts, unused opcodes and queries on an empty store give
// their result word on the cycle after acceptance. A query reads the front and
// back points, runs a binary search with one registered store read per probe
// (up to nine probes), then interpolates x, y and heading with one shared
// multiplier and one bit-serial divider. The block takes one word at a time.
module polyline_arc_length_interpolator
    import pali_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDF  = 4'd1;
    localparam logic [3:0] S_RDB  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_SRCH = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_END  = 4'd6;
    localparam logic [3:0] S_LOW  = 4'd7;
    localparam logic [3:0] S_UP   = 4'd8;
    localparam logic [3:0] S_MUL1 = 4'd9;
    localparam logic [3:0] S_MUL2 = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_WAIT = 4'd12;
    localparam logic [3:0] S_PUSH = 4'd13;

    t_point              r_mem [POINTS];
    t_point              r_rd;
    logic [IDX_W-1:0]    w_rd_addr;

    logic [3:0]          r_state;
    logic [IDX_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_count;
    logic [23:0]         r_lane_length;
    logic [7:0]          r_end_tol;
    logic                r_out_valid;
    t_out_word           r_out;
    t_out_word           r_res;
    logic [23:0]         r_q;
    logic [23:0]         r_sf;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [CNT_W-1:0]    r_mid;
    t_point              r_plo;
    t_point              r_pup;
    logic [23:0]         r_dl;
    logic [23:0]         r_du;
    logic [1:0]          r_phase;
    logic signed [NUM_W-1:0] r_acc;

    logic                w_out_free;
    logic                w_accept;
    logic                w_push;
    logic                w_full;
    logic [CNT_W-1:0]    w_mid;
    logic [IDX_W-1:0]    w_back;
    logic [23:0]         w_mirror;
    logic signed [31:0]  w_mul_a;
    logic [23:0]         w_mul_b;
    logic signed [56:0]  w_prod;
    logic [15:0]         w_hdiff;
    logic signed [24:0]  w_dl;
    logic signed [24:0]  w_du;
    logic                w_div_start;
    logic                w_div_done;
    logic signed [NUM_W-1:0] w_quot;
    t_out_word           w_imm;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !(r_state == S_IDLE && w_out_free);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_push      = (r_state == S_IDLE && w_accept &&
                          !(i_in_word.opcode == OP_QUERY && r_count != '0)) ||
                         (r_state == S_PUSH && w_out_free);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign w_full   = r_count == CNT_W'(POINTS);
    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_back   = r_head + IDX_W'(r_count - 1'b1);
    assign w_mirror = (r_lane_length >= i_in_word.s_pos) ?
                      (r_lane_length - i_in_word.s_pos) : 24'd0;
    assign w_hdiff  = r_pup.heading - r_plo.heading;
    assign w_dl     = $signed({1'b0, r_q}) - $signed({1'b0, r_plo.s});
    assign w_du     = $signed({1'b0, r_rd.s}) - $signed({1'b0, r_q});

    always_comb begin
        w_mul_a = '0;
        case (r_phase)
            2'd0: w_mul_a = (r_state == S_MUL1) ? r_plo.x : r_pup.x;
            2'd1: w_mul_a = (r_state == S_MUL1) ? r_plo.y : r_pup.y;
            2'd2: w_mul_a = (r_state == S_MUL1) ? 32'sd0 :
                            $signed({{16{w_hdiff[15]}}, w_hdiff});
            default: w_mul_a = '0;
        endcase
    end
    assign w_mul_b = (r_state == S_MUL1) ? r_du : r_dl;
    assign w_prod  = w_mul_a * $signed({1'b0, w_mul_b});

    assign w_div_start = r_state == S_DIV;

    pali_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_acc),
        .i_den   (24'(r_dl + r_du)),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_rd_addr = r_head;
        case (r_state)
            S_RDB:  w_rd_addr = w_back;
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    w_rd_addr = r_head + IDX_W'(w_mid);
                end else if (r_lo >= r_count) begin
                    w_rd_addr = w_back;
                end else if (r_lo == '0) begin
                    w_rd_addr = r_head;
                end else begin
                    w_rd_addr = r_head + IDX_W'(r_lo - 1'b1);
                end
            end
            S_LOW:  w_rd_addr = r_head + IDX_W'(r_lo);
            default: w_rd_addr = r_head;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_rd_addr];
        if (w_accept && !w_full) begin
            if (i_in_word.opcode == OP_APPEND) begin
                r_mem[r_head + IDX_W'(r_count)] <= '{i_in_word.x_pos, i_in_word.y_pos,
                    i_in_word.heading, i_in_word.s_pos};
            end else if (i_in_word.opcode == OP_REVERSE) begin
                r_mem[r_head - 1'b1] <= '{i_in_word.x_pos, i_in_word.y_pos,
                    i_in_word.heading + HALF_TURN, w_mirror};
            end
        end
    end

    always_comb begin
        w_imm = '0;
        if ((i_in_word.opcode == OP_APPEND || i_in_word.opcode == OP_REVERSE) && w_full) begin
            w_imm.status = ST_FULL;
        end else if (i_in_word.opcode == OP_QUERY) begin
            w_imm.status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_count       <= '0;
            r_lane_length <= '0;
            r_end_tol     <= 8'd3;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_LANE_LENGTH) begin
                    r_lane_length <= i_cfg_data;
                end else begin
                    r_end_tol <= i_cfg_data[7:0];
                end
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_word.opcode == OP_QUERY && r_count != '0) begin
                            r_q     <= i_in_word.s_pos;
                            r_res   <= '0;
                            r_state <= S_RDF;
                        end else begin
                            r_out <= w_imm;
                            if (!w_full && i_in_word.opcode == OP_APPEND) begin
                                r_count <= r_count + 1'b1;
                            end else if (!w_full && i_in_word.opcode == OP_REVERSE) begin
                                r_count <= r_count + 1'b1;
                                r_head  <= r_head - 1'b1;
                            end
                        end
                    end
                end
                S_RDF:  r_state <= S_RDB;
                S_RDB: begin
                    r_sf    <= r_rd.s;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_lo <= '0;
                    r_hi <= r_count;
                    if ({1'b0, r_q} > {1'b0, r_rd.s} + {17'd0, r_end_tol} ||
                        {1'b0, r_q} + {17'd0, r_end_tol} < {1'b0, r_sf}) begin
                        r_res.status <= ST_OUT;
                        r_state      <= S_PUSH;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_state <= S_CMP;
                    end else if (r_lo >= r_count || r_lo == '0) begin
                        r_state <= S_END;
                    end else begin
                        r_state <= S_LOW;
                    end
                end
                S_CMP: begin
                    if (r_q < r_rd.s) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo <= r_mid + 1'b1;
                    end
                    r_state <= S_SRCH;
                end
                S_END: begin
                    r_res   <= '{ST_OK, r_rd.x, r_rd.y, r_rd.heading, r_rd.s};
                    r_state <= S_PUSH;
                end
                S_LOW: begin
                    r_plo   <= r_rd;
                    r_state <= S_UP;
                end
                S_UP: begin
                    if (w_dl <= 25'sd0 || w_du <= 25'sd0) begin
                        r_res   <= '{ST_OK, r_plo.x, r_plo.y, r_plo.heading, r_q};
                        r_state <= S_PUSH;
                    end else begin
                        r_pup   <= r_rd;
                        r_dl    <= w_dl[23:0];
                        r_du    <= w_du[23:0];
                        r_phase <= 2'd0;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_acc   <= NUM_W'(w_prod);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc   <= r_acc + NUM_W'(w_prod);
                    r_state <= S_DIV;
                end
                S_DIV:  r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_div_done) begin
                        case (r_phase)
                            2'd0: r_res.out_x <= w_quot[31:0];
                            2'd1: r_res.out_y <= w_quot[31:0];
                            default: begin
                                r_res.out_heading <= r_plo.heading + w_quot[15:0];
                                r_res.out_s       <= r_q;
                                r_res.status      <= ST_OK;
                            end
                        endcase
                        if (r_phase == 2'd2) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_phase <= r_phase + 1'b1;
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_PUSH: begin
                    if (w_out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== dv/polyline_arc_length_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_arc_length_interpolator_tb
// Self-checking testbench: a directed table, then three random phases with
// different register settings and idle patterns. Results are checked against
// a behavioural model of the point store and arc-length lookup, or the table.
// ----------------------------------------------------------------------------
module polyline_arc_length_interpolator_tb;
    import pali_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        t_in_word  word;
        bit        fixed;
        t_out_word result;
    } t_row;

    typedef struct {
        bit        fixed;
        t_out_word result;
    } t_pending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_LANE_LENGTH;
    logic [23:0] i_cfg_data = '0;

    polyline_arc_length_interpolator dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Model state
    logic signed [31:0] pt_x [POINTS];
    logic signed [31:0] pt_y [POINTS];
    logic [15:0]        pt_h [POINTS];
    logic [23:0]        pt_s [POINTS];
    int                 pt_head = 0;
    int                 pt_count = 0;
    logic [23:0]        lane_len = '0;
    logic [7:0]         end_tol = 8'd3;

    t_pending    pending_results [$];
    int          fail_count = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          queries_sent = 0;
    int          settings_used = 0;
    int          tx_idle = 0;
    int          rx_idle = 0;
    longint      cycles = 0;
    t_row        rows [$];

    function automatic int slot(int k);
        return (pt_head + k) % POINTS;
    endfunction

    function automatic t_out_word lookup_point(int p, logic [23:0] s);
        t_out_word r;
        r = '0;
        r.status = ST_OK;
        r.out_x = pt_x[p];
        r.out_y = pt_y[p];
        r.out_heading = pt_h[p];
        r.out_s = s;
        return r;
    endfunction

    function automatic t_out_word arc_predict(t_in_word w);
        t_out_word r;
        longint    q, dl, du, d, xv, yv, diff, hv;
        int        lo, hi, mid, pf, pb, pl, pu;
        logic [23:0] s_new;
        r = '0;
        r.status = ST_OK;
        if (w.opcode == OP_APPEND || w.opcode == OP_REVERSE) begin
            if (pt_count >= POINTS) begin
                r.status = ST_FULL;
                return r;
            end
            if (w.opcode == OP_APPEND) begin
                pl = slot(pt_count);
                pt_h[pl] = w.heading;
                pt_s[pl] = w.s_pos;
            end else begin
                s_new = (lane_len >= w.s_pos) ? lane_len - w.s_pos : '0;
                pt_head = (pt_head + POINTS - 1) % POINTS;
                pl = pt_head;
                pt_h[pl] = w.heading + HALF_TURN;
                pt_s[pl] = s_new;
            end
            pt_x[pl] = w.x_pos;
            pt_y[pl] = w.y_pos;
            pt_count++;
            return r;
        end
        if (w.opcode != OP_QUERY) return r;
        if (pt_count == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        pf = slot(0);
        pb = slot(pt_count - 1);
        q = w.s_pos;
        if (q > longint'(pt_s[pb]) + longint'(end_tol) ||
            q < longint'(pt_s[pf]) - longint'(end_tol)) begin
            r.status = ST_OUT;
            return r;
        end
        lo = 0;
        hi = pt_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (q < longint'(pt_s[slot(mid)])) hi = mid;
            else lo = mid + 1;
        end
        if (lo >= pt_count) return lookup_point(pb, pt_s[pb]);
        if (lo == 0) return lookup_point(pf, pt_s[pf]);
        pl = slot(lo - 1);
        pu = slot(lo);
        dl = q - longint'(pt_s[pl]);
        du = longint'(pt_s[pu]) - q;
        if (dl <= 0 || du <= 0) return lookup_point(pl, w.s_pos);
        d = dl + du;
        xv = (longint'(pt_x[pl]) * du + longint'(pt_x[pu]) * dl) / d;
        yv = (longint'(pt_y[pl]) * du + longint'(pt_y[pu]) * dl) / d;
        diff = longint'($signed(16'(pt_h[pu] - pt_h[pl])));
        hv = longint'(pt_h[pl]) + (diff * dl) / d;
        r.out_x = xv[31:0];
        r.out_y = yv[31:0];
        r.out_heading = hv[15:0];
        r.out_s = w.s_pos;
        return r;
    endfunction

    task automatic send_word(t_in_word w, bit fixed, t_out_word fixed_result);
        t_pending p;
        while ($urandom_range(99) < tx_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        p.result = arc_predict(w);
        p.fixed = fixed;
        if (fixed) p.result = fixed_result;
        pending_results.insert(pending_results.size(), p);
        words_sent++;
        if (w.opcode == OP_QUERY) queries_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LANE_LENGTH) lane_len = data;
        else end_tol = data[7:0];
    endtask

    task automatic set_lane(logic [23:0] len, logic [7:0] tol);
        write_reg(CFG_LANE_LENGTH, len);
        write_reg(CFG_END_TOL, {16'd0, tol});
        settings_used++;
    endtask

    function automatic t_row row(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                 logic [15:0] h, logic [23:0] s, bit fixed = 1'b0,
                                 t_out_word res = '0);
        t_row r;
        r.word = '{op, x, y, h, s};
        r.fixed = fixed;
        r.result = res;
        return r;
    endfunction

    function automatic void add_row(t_row r);
        rows.insert(rows.size(), r);
    endfunction

    function automatic t_in_word random_word(int insert_pct);
        t_in_word w;
        int       pick;
        longint   lo_s, hi_s, target;
        logic [23:0] front_s, back_s;
        w.x_pos = $urandom;
        w.y_pos = $urandom;
        w.heading = 16'($urandom);
        w.s_pos = 24'($urandom);
        pick = $urandom_range(99);
        front_s = pt_count ? pt_s[slot(0)] : 24'h800000;
        back_s = pt_count ? pt_s[slot(pt_count - 1)] : 24'h800000;
        if (pick < 3) begin
            w.opcode = 2'($urandom_range(3));
        end else if (pick < insert_pct) begin
            if ($urandom_range(3) == 0) begin
                w.opcode = OP_REVERSE;
                target = longint'(front_s) - $urandom_range(1, 3000);
                if (target < 0) target = 0;
                if (lane_len >= target) w.s_pos = 24'(lane_len - target);
            end else begin
                w.opcode = OP_APPEND;
                target = longint'(back_s) + $urandom_range(1, 3000);
                if (target > 24'hFFFFFF) target = 24'hFFFFFF;
                if ($urandom_range(9) != 0) w.s_pos = target[23:0];
            end
        end else begin
            w.opcode = OP_QUERY;
            if ($urandom_range(4) != 0) begin
                lo_s = longint'(front_s) - end_tol - 8;
                hi_s = longint'(back_s) + end_tol + 8;
                if (lo_s < 0) lo_s = 0;
                if (hi_s > 24'hFFFFFF) hi_s = 24'hFFFFFF;
                w.s_pos = 24'($urandom_range(32'(hi_s), 32'(lo_s)));
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_idle);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_pending p;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %p", $realtime, o_out_word);
                fail_count++;
            end else begin
                p = pending_results.pop_front();
                words_checked++;
                if (o_out_word.status !== p.result.status)
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             p.result.status, o_out_word.status);
                if (o_out_word.out_x !== p.result.out_x)
                    $display("%0t: out_x expected %0d actual %0d", $realtime,
                             p.result.out_x, o_out_word.out_x);
                if (o_out_word.out_y !== p.result.out_y)
                    $display("%0t: out_y expected %0d actual %0d", $realtime,
                             p.result.out_y, o_out_word.out_y);
                if (o_out_word.out_heading !== p.result.out_heading)
                    $display("%0t: out_heading expected %h actual %h", $realtime,
                             p.result.out_heading, o_out_word.out_heading);
                if (o_out_word.out_s !== p.result.out_s)
                    $display("%0t: out_s expected %0d actual %0d", $realtime,
                             p.result.out_s, o_out_word.out_s);
                if (o_out_word !== p.result) fail_count++;
            end
        end
    end

    initial begin
        t_out_word ok_zero, empty_res, out_res, front_res;
        ok_zero = '0;
        empty_res = '0;
        empty_res.status = ST_EMPTY;
        out_res = '0;
        out_res.status = ST_OUT;
        front_res = '{ST_OK, 32'sd100, -32'sd100, 16'h9234, 24'd500};

        // The reversed points below assume a lane length of 1 000 000.
        add_row(row(OP_QUERY, 0, 0, 0, 0, 1'b1, empty_res));
        add_row(row(OP_APPEND, 32'h7FFFFFFF, 32'h80000000, 16'h0000, 24'd1000));
        add_row(row(OP_APPEND, -32'sd256, 32'sd512, 16'hFFFF, 24'd2000));
        add_row(row(OP_APPEND, 32'h80000000, 32'h7FFFFFFF, 16'h4000, 24'd5000));
        add_row(row(OP_REVERSE, 32'sd100, -32'sd100, 16'h1234, 24'd999500));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd500, 1'b1, front_res));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd497));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd496, 1'b1, out_res));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd1000));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd1500));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd1999));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd3000));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd5003));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd5004, 1'b1, out_res));
        add_row(row(2'b11, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF,
                    1'b1, ok_zero));
        add_row(row(OP_REVERSE, 32'sd7, 32'sd9, 16'h8001, 24'hFFFFFF));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd0));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd250));
        add_row(row(OP_APPEND, 32'sd1, 32'sd2, 16'h0001, 24'd5000));
        add_row(row(OP_QUERY, 0, 0, 0, 24'd5000));
        add_row(row(OP_APPEND, -32'sd1, 32'sd0, 16'hC000, 24'hFFFFFF));
        add_row(row(OP_QUERY, 0, 0, 0, 24'h800000));
        add_row(row(OP_QUERY, 0, 0, 0, 24'hFFFFFF));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_lane(24'd1000000, 8'd3);
        tx_idle = 21;
        rx_idle = 78;
        foreach (rows[i]) send_word(rows[i].word, rows[i].fixed, rows[i].result);
        wait_drained();

        set_lane(24'hFFFFFF, 8'd0);
        repeat (150) send_word(random_word(30), 1'b0, ok_zero);
        wait_drained();

        tx_idle = 78;
        rx_idle = 21;
        set_lane(24'd0, 8'd255);
        while (pt_count < POINTS) send_word(random_word(85), 1'b0, ok_zero);
        repeat (10) send_word(random_word(85), 1'b0, ok_zero);
        wait_drained();

        tx_idle = 0;
        rx_idle = 0;
        set_lane(24'd12000000, 8'd40);
        repeat (150) send_word(random_word(10), 1'b0, ok_zero);
        wait_drained();

        $display("Sent %0d words (%0d queries) over %0d register settings;",
                 words_sent, queries_sent, settings_used);
        $display("checked %0d result words, store filled to %0d points.",
                 words_checked, pt_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== polyline_arc_length_interpolator.f =====
src/pali_pkg.sv
src/pali_div.sv
src/polyline_arc_length_interpolator.sv
dv/polyline_arc_length_interpolator_tb.sv
